[rtl/gbce_pkg.sv]
`timescale 1ns / 1ps
// Package for the grid box cell enumerator: register indexes, widths,
// parameter defaults and the control word of the shared multiply unit.
// No dependencies.
package gbce_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_CELLS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Z  = 3'd6;

	// Fixed field widths
	localparam int CELLS_W  = 3;   // cells_per_axis register
	localparam int CELL_W   = 3;   // per-axis cell coordinate, holds 0..4
	localparam int INDEX_W  = 6;   // linear cell index
	localparam int ORIGIN_W = 32;
	localparam int SCALE_W  = 32;
	localparam int PROD_W   = 64;

	// Parameter defaults
	localparam int DEF_RANK      = 3;
	localparam int DEF_MAX_CELLS = 4;
	localparam int DEF_COORD_W   = 32;

	// Control word of the shared multiply-accumulate unit
	typedef struct packed {
		logic mul;   // register operand * scale
		logic init;  // accumulator <= registered product >> 32
		logic add;   // accumulator <= accumulator + registered product
	} gbce_mac_ctl_t;

endpackage

[rtl/gbce_if.sv]
`timescale 1ns / 1ps
// Channel interfaces of the grid box cell enumerator: box input and cell output.
// Valid/ready handshake; no package dependency.
interface gbce_box_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] lo_x;
	logic signed [COORD_WIDTH-1:0] lo_y;
	logic signed [COORD_WIDTH-1:0] lo_z;
	logic signed [COORD_WIDTH-1:0] hi_x;
	logic signed [COORD_WIDTH-1:0] hi_y;
	logic signed [COORD_WIDTH-1:0] hi_z;

	modport source (output valid, output lo_x, output lo_y, output lo_z,
		output hi_x, output hi_y, output hi_z, input ready);
	modport sink (input valid, input lo_x, input lo_y, input lo_z,
		input hi_x, input hi_y, input hi_z, output ready);
endinterface

interface gbce_cell_if;
	logic       valid;
	logic       ready;
	logic [5:0] cell_index;
	logic       last;

	modport source (output valid, output cell_index, output last, input ready);
	modport sink (input valid, input cell_index, input last, output ready);
endinterface

[rtl/gbce_mac.sv]
`timescale 1ns / 1ps
// Shared 32x32 multiply-accumulate unit: registered product, then accumulate.
// Depends on gbce_pkg.
module gbce_mac (
	input  logic                   clk,
	input  gbce_pkg::gbce_mac_ctl_t ctl,
	input  logic [31:0]            opnd,
	input  logic [31:0]            scale,
	output logic [63:0]            acc
);
	import gbce_pkg::*;

	logic [PROD_W-1:0] prod;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] acc_q;

	assign prod = opnd * scale;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_q <= prod;
		end
		if (ctl.init) begin
			acc_q <= {32'b0, prod_q[PROD_W-1:32]};
		end else if (ctl.add) begin
			acc_q <= acc_q + prod_q;
		end
	end

	assign acc = acc_q;
endmodule

[rtl/grid_box_cell_enumerator.sv]
`timescale 1ns / 1ps
// Top level of the grid box cell enumerator: sequencer, clamp and cell walk.
// Depends on gbce_pkg, gbce_if (gbce_box_if, gbce_cell_if) and gbce_mac.
//
// Usage
//   box   : one axis-aligned box (lo_* and hi_*, signed Q16.16) per transaction.
//   cells : one linear cell index per transaction, x fastest, then y, then z;
//           last marks the final cell of the box. A box inverted on any axis or
//           wholly below the grid gives no transaction; one above it clamps to the last cell.
//   cfg   : cfg_we writes cfg_data to register cfg_index; write only
//           while the block is idle. Indexes outside the register list are dropped.
// Timing
//   Each used axis takes two endpoints, and each endpoint goes through six steps
//   of one sequencer (subtract, magnitude, low product, high product, add, clamp)
//   around a single shared 32x32 multiplier. The done state then checks for an
//   empty range, then cells leave at one per cycle from the output register
//   while cells.ready is high; box.ready is high only between boxes.
// Reset
//   arst_n clears the sequencer and the output valid and loads the register
//   reset values (one cell per axis, zero origin, zero scale).
// Stall
//   A low cells.ready holds the output register and the cell walk; the next
//   box may be taken while the final cell of the previous one still waits.
module grid_box_cell_enumerator #(
	parameter int RANK               = gbce_pkg::DEF_RANK,
	parameter int MAX_CELLS_PER_AXIS = gbce_pkg::DEF_MAX_CELLS,
	parameter int COORD_WIDTH        = gbce_pkg::DEF_COORD_W
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [gbce_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gbce_pkg::CFG_DATA_W-1:0]  cfg_data,
	gbce_box_if.sink                         box,
	gbce_cell_if.source                      cells
);
	import gbce_pkg::*;

	// Difference width: covers coordinate minus origin without overflow.
	localparam int DW = ((COORD_WIDTH > ORIGIN_W) ? COORD_WIDTH : ORIGIN_W) + 1;
	localparam logic [1:0]        LAST_AXIS = 2'(RANK - 1);
	localparam logic [CELL_W-1:0] MAX_N     = CELL_W'(MAX_CELLS_PER_AXIS);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_SUB  = 9'b000000010,
		ST_ABS  = 9'b000000100,
		ST_MLO  = 9'b000001000,
		ST_MHI  = 9'b000010000,
		ST_ACC  = 9'b000100000,
		ST_CLMP = 9'b001000000,
		ST_DONE = 9'b010000000,
		ST_EMIT = 9'b100000000
	} state_t;

	// Configuration registers
	logic        [CELLS_W-1:0]  cells_q;
	logic signed [ORIGIN_W-1:0] origin_q [0:2];
	logic        [SCALE_W-1:0]  scale_q  [0:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q     <= CELLS_W'(1);
			origin_q[0] <= '0;
			origin_q[1] <= '0;
			origin_q[2] <= '0;
			scale_q[0]  <= '0;
			scale_q[1]  <= '0;
			scale_q[2]  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CELLS:    cells_q     <= cfg_data[CELLS_W-1:0];
				CFG_ORIGIN_X: origin_q[0] <= cfg_data;
				CFG_ORIGIN_Y: origin_q[1] <= cfg_data;
				CFG_ORIGIN_Z: origin_q[2] <= cfg_data;
				CFG_SCALE_X:  scale_q[0]  <= cfg_data;
				CFG_SCALE_Y:  scale_q[1]  <= cfg_data;
				CFG_SCALE_Z:  scale_q[2]  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Effective cells per axis: zero reads as one, saturate at the maximum.
	logic [CELL_W-1:0] n;
	always_comb begin
		priority if (cells_q == '0) begin
			n = CELL_W'(1);
		end else if (cells_q > MAX_N) begin
			n = MAX_N;
		end else begin
			n = cells_q;
		end
	end

	// Sequencer and working registers
	state_t                         state_q;
	logic [1:0]                     axis_q;
	logic                           end_q;     // 0: lo endpoint, 1: hi endpoint
	logic                           inv_q;     // some used axis has lo above hi
	logic signed [COORD_WIDTH-1:0]  lo_q [0:2];
	logic signed [COORD_WIDTH-1:0]  hi_q [0:2];
	logic [DW-1:0]                  d_q;
	logic [DW-1:0]                  mag_q;
	logic                           neg_q;
	logic [CELL_W-1:0]              first_q [0:2];
	logic [CELL_W-1:0]              last_q  [0:2];
	logic [CELL_W-1:0]              i_q, j_q, k_q;

	logic box_fire;
	assign box.ready = (state_q == ST_IDLE);
	assign box_fire  = box.valid && box.ready;

	// Inverted box check on the incoming corners
	logic inv_in;
	always_comb begin
		inv_in = 1'b0;
		if (RANK > 0 && box.lo_x > box.hi_x) inv_in = 1'b1;
		if (RANK > 1 && box.lo_y > box.hi_y) inv_in = 1'b1;
		if (RANK > 2 && box.lo_z > box.hi_z) inv_in = 1'b1;
	end

	// Endpoint minus origin, both sign-extended to DW
	logic signed [COORD_WIDTH-1:0] coord_sel;
	logic [DW-1:0]                 coord_ext;
	logic [DW-1:0]                 org_ext;
	assign coord_sel = end_q ? hi_q[axis_q] : lo_q[axis_q];
	assign coord_ext = {{(DW-COORD_WIDTH){coord_sel[COORD_WIDTH-1]}}, coord_sel};
	assign org_ext   = {{(DW-ORIGIN_W){origin_q[axis_q][ORIGIN_W-1]}}, origin_q[axis_q]};

	// Shared multiplier: low word of the magnitude first, then the high word.
	gbce_mac_ctl_t mac_ctl;
	logic [31:0]   mac_opnd;
	logic [63:0]   mac_acc;

	always_comb begin
		mac_ctl      = '0;
		mac_ctl.mul  = (state_q == ST_MLO) || (state_q == ST_MHI);
		mac_ctl.init = (state_q == ST_MHI);
		mac_ctl.add  = (state_q == ST_ACC);
		mac_opnd     = (state_q == ST_MHI) ? 32'(mag_q[DW-1:32]) : mag_q[31:0];
	end

	gbce_mac u_mac (
		.clk   (clk),
		.ctl   (mac_ctl),
		.opnd  (mac_opnd),
		.scale (scale_q[axis_q]),
		.acc   (mac_acc)
	);

	// Clamp of the truncated product. A negative nonzero result sits below
	// the grid; a result at or above n sits above it.
	logic              q_below, q_above;
	logic [CELL_W-1:0] q_low, q_inc, first_val, last_val, last_raw;
	assign q_below = neg_q && (mac_acc != '0);
	assign q_low   = mac_acc[CELL_W-1:0];
	assign q_above = (|mac_acc[63:CELL_W]) || (q_low >= n);
	assign q_inc   = q_low + CELL_W'(1);

	always_comb begin
		priority if (q_below) begin
			first_val = '0;
		end else if (q_above) begin
			first_val = n - CELL_W'(1);
		end else begin
			first_val = q_low;
		end
		last_raw = q_above ? n : q_inc;
		priority if (q_below) begin
			last_val = first_q[axis_q];
		end else if (last_raw < first_q[axis_q]) begin
			last_val = first_q[axis_q];
		end else begin
			last_val = last_raw;
		end
	end

	// Cell walk
	logic [CELL_W-1:0]  i_nx, j_nx, k_nx;
	logic [INDEX_W-1:0] n6, idx;
	logic               final_cell, empty, load;
	assign i_nx = i_q + CELL_W'(1);
	assign j_nx = j_q + CELL_W'(1);
	assign k_nx = k_q + CELL_W'(1);
	assign final_cell = (i_nx == last_q[0]) && (j_nx == last_q[1]) && (k_nx == last_q[2]);
	assign n6  = INDEX_W'(n);
	assign idx = INDEX_W'(i_q) + n6 * INDEX_W'(j_q) + n6 * n6 * INDEX_W'(k_q);
	assign empty = inv_q || (last_q[0] == first_q[0]) || (last_q[1] == first_q[1])
		|| (last_q[2] == first_q[2]);

	// Output register
	logic               ovalid_q;
	logic [INDEX_W-1:0] oidx_q;
	logic               olast_q;
	assign load = (state_q == ST_EMIT) && (!ovalid_q || cells.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (load) begin
			ovalid_q <= 1'b1;
		end else if (cells.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			oidx_q  <= idx;
			olast_q <= final_cell;
		end
	end

	assign cells.valid      = ovalid_q;
	assign cells.cell_index = oidx_q;
	assign cells.last       = olast_q;

	// Sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			end_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (box_fire) begin
						state_q <= ST_SUB;
						axis_q  <= '0;
						end_q   <= 1'b0;
					end
				end
				ST_SUB:  state_q <= ST_ABS;
				ST_ABS:  state_q <= ST_MLO;
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_ACC;
				ST_ACC:  state_q <= ST_CLMP;
				ST_CLMP: begin
					if (!end_q) begin
						end_q   <= 1'b1;
						state_q <= ST_SUB;
					end else if (axis_q == LAST_AXIS) begin
						state_q <= ST_DONE;
					end else begin
						end_q   <= 1'b0;
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_SUB;
					end
				end
				ST_DONE: state_q <= empty ? ST_IDLE : ST_EMIT;
				ST_EMIT: begin
					if (load && final_cell) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (box_fire) begin
			lo_q[0]    <= box.lo_x;
			lo_q[1]    <= box.lo_y;
			lo_q[2]    <= box.lo_z;
			hi_q[0]    <= box.hi_x;
			hi_q[1]    <= box.hi_y;
			hi_q[2]    <= box.hi_z;
			inv_q      <= inv_in;
			// Unused axes contribute cell 0 only.
			first_q[0] <= '0;
			first_q[1] <= '0;
			first_q[2] <= '0;
			last_q[0]  <= CELL_W'(1);
			last_q[1]  <= CELL_W'(1);
			last_q[2]  <= CELL_W'(1);
		end
		if (state_q == ST_SUB) begin
			d_q <= coord_ext - org_ext;
		end
		if (state_q == ST_ABS) begin
			neg_q <= d_q[DW-1];
			mag_q <= d_q[DW-1] ? (~d_q + DW'(1)) : d_q;
		end
		if (state_q == ST_CLMP) begin
			if (!end_q) begin
				first_q[axis_q] <= first_val;
			end else begin
				last_q[axis_q] <= last_val;
			end
		end
		if (state_q == ST_DONE) begin
			i_q <= first_q[0];
			j_q <= first_q[1];
			k_q <= first_q[2];
		end
		// Advance x, wrap into y, then z.
		if (load) begin
			if (i_nx != last_q[0]) begin
				i_q <= i_nx;
			end else begin
				i_q <= first_q[0];
				if (j_nx != last_q[1]) begin
					j_q <= j_nx;
				end else begin
					j_q <= first_q[1];
					k_q <= k_nx;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		axis_q <= LAST_AXIS)
		else $error("axis counter beyond the last used axis");

	a_clamp_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLMP) && end_q && (axis_q == LAST_AXIS) |=> (state_q == ST_DONE))
		else $error("sequencer missed the range check after the last axis");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (last_q[0] >= first_q[0]) && (last_q[1] >= first_q[1])
			&& (last_q[2] >= first_q[2]))
		else $error("axis range ends below its start");

	a_final_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load && final_cell |=> (state_q == ST_IDLE) && cells.valid && cells.last)
		else $error("final cell did not end the box");
`endif

endmodule
